>>> hdl/itaf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itaf_pkg - shared types and constants of the integer to ASCII formatter
// Conversion codes, micro-instruction format, status bundle, the control
// store contents and the digit-to-character lookup.
// ----------------------------------------------------------------------------
package itaf_pkg;

    // Conversion kinds carried on tuser
    localparam logic [2:0] OP_D       = 3'd0;
    localparam logic [2:0] OP_I       = 3'd1;
    localparam logic [2:0] OP_U       = 3'd2;
    localparam logic [2:0] OP_X_LOWER = 3'd3;
    localparam logic [2:0] OP_X_UPPER = 3'd4;
    localparam logic [2:0] OP_P       = 3'd5;

    // Fixed characters
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_UPPER_A = 8'h41;

    // Digit counts and loop length
    localparam logic [4:0] NDIG_PTR  = 5'd16;
    localparam logic [4:0] NDIG_HEX  = 5'd8;
    localparam logic [4:0] NDIG_DEC  = 5'd10;
    localparam logic [4:0] DABBLE_LAST = 5'd31;

    // Step addresses of the control store
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] STEP_WAIT   = 4'd0;
    localparam logic [PC_W-1:0] STEP_CHECK  = 4'd1;
    localparam logic [PC_W-1:0] STEP_ROUTE  = 4'd2;
    localparam logic [PC_W-1:0] STEP_DABBLE = 4'd3;
    localparam logic [PC_W-1:0] STEP_SKIP   = 4'd4;
    localparam logic [PC_W-1:0] STEP_MINUS  = 4'd5;
    localparam logic [PC_W-1:0] STEP_ZERO   = 4'd6;
    localparam logic [PC_W-1:0] STEP_X      = 4'd7;
    localparam logic [PC_W-1:0] STEP_DIGIT  = 4'd8;
    localparam logic [PC_W-1:0] STEP_RETURN = 4'd9;

    // Datapath operations
    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,
        DP_DABBLE,
        DP_SKIP,
        DP_DIGIT
    } dp_op_t;

    // Character emission select
    typedef enum logic [2:0] {
        EM_NONE,
        EM_MINUS,
        EM_ZERO,
        EM_X,
        EM_DIGIT
    } emit_t;

    // Jump conditions
    typedef enum logic [2:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_BAD,
        JC_HEX,
        JC_ITER,
        JC_SKIP,
        JC_MORE
    } jcond_t;

    // One control word
    typedef struct packed {
        dp_op_t          dp_op;
        emit_t           emit;
        jcond_t          jcond;
        logic [PC_W-1:0] target;
    } uword_t;

    // Datapath status back to the sequencer
    typedef struct packed {
        logic       neg;
        logic       ptr;
        logic       bad;
        logic       hex;
        logic       iter_more;
        logic       skip_more;
        logic       more;
        logic [7:0] digit;
    } dp_status_t;

    // Control store
    function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
        uword_t w;
        w = '{dp_op: DP_NOP, emit: EM_NONE, jcond: JC_ALWAYS, target: STEP_WAIT};
        unique case (pc)
            STEP_WAIT:   w = '{DP_LOAD,   EM_NONE,  JC_NEXT,   STEP_WAIT};
            STEP_CHECK:  w = '{DP_NOP,    EM_NONE,  JC_BAD,    STEP_WAIT};
            STEP_ROUTE:  w = '{DP_NOP,    EM_NONE,  JC_HEX,    STEP_SKIP};
            STEP_DABBLE: w = '{DP_DABBLE, EM_NONE,  JC_ITER,   STEP_DABBLE};
            STEP_SKIP:   w = '{DP_SKIP,   EM_NONE,  JC_SKIP,   STEP_SKIP};
            STEP_MINUS:  w = '{DP_NOP,    EM_MINUS, JC_NEXT,   STEP_WAIT};
            STEP_ZERO:   w = '{DP_NOP,    EM_ZERO,  JC_NEXT,   STEP_WAIT};
            STEP_X:      w = '{DP_NOP,    EM_X,     JC_NEXT,   STEP_WAIT};
            STEP_DIGIT:  w = '{DP_DIGIT,  EM_DIGIT, JC_MORE,   STEP_DIGIT};
            STEP_RETURN: w = '{DP_NOP,    EM_NONE,  JC_ALWAYS, STEP_WAIT};
            default:     w = '{DP_NOP,    EM_NONE,  JC_ALWAYS, STEP_WAIT};
        endcase
        return w;
    endfunction

    // Nibble to ASCII digit
    function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
        logic [7:0] c;
        if (nib < 4'd10)
            c = CH_ZERO + {4'h0, nib};
        else
            c = (upper ? CH_UPPER_A : CH_LOWER_A) + {4'h0, nib} - 8'd10;
        return c;
    endfunction

endpackage
`default_nettype wire

>>> hdl/itaf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itaf_datapath - digit datapath of the formatter
// Holds the binary magnitude and a 16-nibble digit register aligned at the
// top; does the load, one shift-add-3 step, leading zero skip and digit pop.
// ----------------------------------------------------------------------------
module itaf_datapath
    import itaf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dp_op_t      dp_op,
    input  wire logic [2:0]  operation,
    input  wire logic [63:0] value,
    output dp_status_t       status
);

    logic [31:0] num_reg,  num_next;
    logic [63:0] dig_reg,  dig_next;
    logic [4:0]  cnt_reg,  cnt_next;
    logic [4:0]  iter_reg, iter_next;
    logic        neg_reg,  neg_next;
    logic        ptr_reg,  ptr_next;
    logic        bad_reg,  bad_next;
    logic        hex_reg,  hex_next;
    logic        up_reg,   up_next;

    logic [31:0] low;
    logic        signed_op;
    logic        is_hex32;
    logic [39:0] bcd_adj;
    logic        skip_more;

    // 10 BCD digits all in range
    function automatic logic bcd_ok(input logic [39:0] b);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < 10; i++)
            if (b[4*i +: 4] > 4'd9)
                ok = 1'b0;
        return ok;
    endfunction

    assign low       = value[31:0];
    assign signed_op = (operation == OP_D) || (operation == OP_I);
    assign is_hex32  = (operation == OP_X_LOWER) || (operation == OP_X_UPPER);
    assign skip_more = (dig_reg[63:60] == 4'h0) && (cnt_reg != 5'd1);

    // add-3 correction on every BCD nibble
    always_comb
    begin
        for (int i = 0; i < 10; i++)
            bcd_adj[4*i +: 4] = (dig_reg[24 + 4*i +: 4] >= 4'd5) ?
                                dig_reg[24 + 4*i +: 4] + 4'd3 : dig_reg[24 + 4*i +: 4];
    end

    // datapath next values
    always_comb
    begin
        num_next  = num_reg;
        dig_next  = dig_reg;
        cnt_next  = cnt_reg;
        iter_next = iter_reg;
        neg_next  = neg_reg;
        ptr_next  = ptr_reg;
        bad_next  = bad_reg;
        hex_next  = hex_reg;
        up_next   = up_reg;
        unique case (dp_op)
            DP_LOAD:
            begin
                neg_next  = signed_op && low[31];
                num_next  = (signed_op && low[31]) ? (~low + 32'd1) : low;
                ptr_next  = (operation == OP_P);
                bad_next  = (operation > OP_P);
                hex_next  = is_hex32 || (operation == OP_P);
                up_next   = (operation == OP_X_UPPER);
                iter_next = DABBLE_LAST;
                if (operation == OP_P)
                begin
                    dig_next = value;
                    cnt_next = NDIG_PTR;
                end
                else if (is_hex32)
                begin
                    dig_next = {low, 32'h0};
                    cnt_next = NDIG_HEX;
                end
                else
                begin
                    dig_next = '0;
                    cnt_next = NDIG_DEC;
                end
            end
            DP_DABBLE:
            begin
                dig_next  = {bcd_adj[38:0], num_reg[31], 24'h0};
                num_next  = {num_reg[30:0], 1'b0};
                iter_next = iter_reg - 5'd1;
            end
            DP_SKIP:
            begin
                if (skip_more)
                begin
                    dig_next = {dig_reg[59:0], 4'h0};
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            DP_DIGIT:
            begin
                dig_next = {dig_reg[59:0], 4'h0};
                cnt_next = cnt_reg - 5'd1;
            end
            DP_NOP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // control-side counters and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 5'd1;
            iter_reg <= '0;
            neg_reg  <= 1'b0;
            ptr_reg  <= 1'b0;
            bad_reg  <= 1'b0;
            hex_reg  <= 1'b0;
            up_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            iter_reg <= iter_next;
            neg_reg  <= neg_next;
            ptr_reg  <= ptr_next;
            bad_reg  <= bad_next;
            hex_reg  <= hex_next;
            up_reg   <= up_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        dig_reg <= dig_next;
    end

    // status to the sequencer
    always_comb
    begin
        status.neg       = neg_reg;
        status.ptr       = ptr_reg;
        status.bad       = bad_reg;
        status.hex       = hex_reg;
        status.iter_more = (iter_reg != 5'd0);
        status.skip_more = skip_more;
        status.more      = (cnt_reg != 5'd1);
        status.digit     = digit_char(dig_reg[63:60], up_reg);
    end

    // shift-add-3 keeps every decimal digit in range
    a_bcd_range: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_op == DP_DABBLE) |-> bcd_ok(dig_reg[63:24]))
        else $error("BCD digit out of range during conversion");

    // never pop a digit from an empty string
    a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_op == DP_DIGIT || dp_op == DP_SKIP) |-> (cnt_reg != 5'd0))
        else $error("digit count exhausted");

    // dabble loop runs only on decimal conversions
    a_dabble_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_op == DP_DABBLE) |-> !hex_reg)
        else $error("decimal step on a hex conversion");

endmodule
`default_nettype wire

>>> hdl/integer_to_ascii_formatter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter - printf style integer to ASCII text
// Microcoded sequencer over a small digit datapath; one character per
// output transaction, most significant first, tlast on the final one.
// ----------------------------------------------------------------------------
// One transaction in (tuser = conversion kind, tdata = value) yields the
// number's text as a stream of characters: d/i signed decimal of the low 32
// bits with a leading '-', u unsigned decimal, x/X lower/upper hex of the low
// 32 bits, p "0x" plus lower hex of all 64 bits; zero prints as "0". Kinds 6
// and 7 are dropped with no output. Items are handled one at a time. A decimal
// item first runs the 32-step shift-add-3 loop; then z leading zero nibbles
// are skipped one nibble per cycle and the n digits go out, with z + n = 10,
// 8 or 16 in decimal, hex and pointer. Characters go out through a one-deep
// output register, so a stalled sink holds the sequencer only on the step
// that emits the next character.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter
    import itaf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // [63:0] value
    input  wire logic [2:0]  s_axis_tuser,   // [2:0] operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] character
    output logic             m_axis_tlast
);

    logic [PC_W-1:0] pc_reg, pc_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_char_reg,  out_char_next;
    logic            out_last_reg,  out_last_next;

    uword_t     cw;
    dp_status_t st;
    dp_op_t     dp_op;
    logic       emit_active;
    logic       hold;
    logic       advance;
    logic       taken;
    logic       s_accept;
    logic [7:0] emit_char;

    // current control word
    assign cw = ucode_rom(pc_reg);

    assign s_axis_tready = (cw.dp_op == DP_LOAD);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // does this step put out a character
    always_comb
    begin
        unique case (cw.emit)
            EM_MINUS: emit_active = st.neg;
            EM_ZERO:  emit_active = st.ptr;
            EM_X:     emit_active = st.ptr;
            EM_DIGIT: emit_active = 1'b1;
            EM_NONE:  emit_active = 1'b0;
            default:  emit_active = 1'b0;
        endcase
    end

    // stall on missing input or a full output register
    assign hold    = ((cw.dp_op == DP_LOAD) && !s_axis_tvalid) ||
                     (emit_active && out_valid_reg && !m_axis_tready);
    assign advance = !hold;
    assign dp_op   = advance ? cw.dp_op : DP_NOP;

    // jump condition
    always_comb
    begin
        unique case (cw.jcond)
            JC_NEXT:   taken = 1'b0;
            JC_ALWAYS: taken = 1'b1;
            JC_BAD:    taken = st.bad;
            JC_HEX:    taken = st.hex;
            JC_ITER:   taken = st.iter_more;
            JC_SKIP:   taken = st.skip_more;
            JC_MORE:   taken = st.more;
            default:   taken = 1'b0;
        endcase
    end

    // step counter
    always_comb
    begin
        pc_next = pc_reg;
        if (advance)
            pc_next = taken ? cw.target : pc_reg + 1'b1;
    end

    // character select
    always_comb
    begin
        unique case (cw.emit)
            EM_MINUS: emit_char = CH_MINUS;
            EM_ZERO:  emit_char = CH_ZERO;
            EM_X:     emit_char = CH_X;
            EM_DIGIT: emit_char = st.digit;
            EM_NONE:  emit_char = CH_ZERO;
            default:  emit_char = CH_ZERO;
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (advance && emit_active)
        begin
            out_valid_next = 1'b1;
            out_char_next  = emit_char;
            out_last_next  = (cw.emit == EM_DIGIT) && !st.more;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= STEP_WAIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tlast  = out_last_reg;

    // digit datapath
    itaf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .dp_op     (dp_op),
        .operation (s_axis_tuser),
        .value     (s_axis_tdata),
        .status    (st)
    );

    // busy after taking an item
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> !s_axis_tready)
        else $error("input ready straight after a transaction");

    // undefined kinds go straight back to waiting
    a_bad_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == STEP_CHECK) && st.bad |=> (pc_reg == STEP_WAIT))
        else $error("invalid kind not dropped");

    // a character never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit_active) |-> (!out_valid_reg || m_axis_tready))
        else $error("output register overwritten");

endmodule
`default_nettype wire
